@@ hdl/kens_pkg.sv @@
package kens_pkg;

  localparam int AngleFracBits = 27;
  localparam int CordicSteps   = 30;
  localparam int StepW         = 5;

  // Q.30 constants
  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] GainQ30   = 36'sd652032874;
  localparam logic signed [35:0] OneQ30    = 36'sd1073741824;

  // u range is [-2^31, 2^31-1] in Q4.27
  localparam logic signed [35:0] AngMax = 36'sd2147483647;
  localparam logic signed [35:0] AngMin = -36'sd2147483648;

  localparam logic [34:0] StepCap = 35'h2_0000_0000;

  localparam logic [0:0] CfgTolerance = 1'd0;
  localparam logic [0:0] CfgMaxRounds = 1'd1;

  function automatic logic signed [35:0] atan_q30(input logic [StepW-1:0] i);
    logic signed [35:0] v;
    unique case (i)
      5'd0:  v = 36'sd843314856;
      5'd1:  v = 36'sd497837829;
      5'd2:  v = 36'sd263043836;
      5'd3:  v = 36'sd133525158;
      5'd4:  v = 36'sd66987894;
      5'd5:  v = 36'sd33535579;
      5'd6:  v = 36'sd16777898;
      5'd7:  v = 36'sd8388437;
      5'd8:  v = 36'sd4194282;
      5'd9:  v = 36'sd2097149;
      5'd10: v = 36'sd1048575;
      5'd11: v = 36'sd524287;
      5'd12: v = 36'sd262143;
      5'd13: v = 36'sd131071;
      5'd14: v = 36'sd65535;
      5'd15: v = 36'sd32767;
      5'd16: v = 36'sd16383;
      5'd17: v = 36'sd8191;
      5'd18: v = 36'sd4095;
      5'd19: v = 36'sd2047;
      5'd20: v = 36'sd1023;
      5'd21: v = 36'sd511;
      5'd22: v = 36'sd255;
      5'd23: v = 36'sd127;
      5'd24: v = 36'sd63;
      5'd25: v = 36'sd31;
      5'd26: v = 36'sd15;
      5'd27: v = 36'sd8;
      5'd28: v = 36'sd4;
      5'd29: v = 36'sd2;
      default: v = 36'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/kens_in_if.sv @@
interface kens_in_if;
  logic        valid;
  logic        ready;
  logic [29:0] mean_anomaly;
  logic [29:0] eccentricity;
  logic [29:0] initial_guess;
  modport source (output valid, mean_anomaly, eccentricity, initial_guess, input ready);
  modport sink   (input valid, mean_anomaly, eccentricity, initial_guess, output ready);
endinterface

@@ hdl/kens_out_if.sv @@
interface kens_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eccentric_anomaly;
  logic               converged;
  logic [7:0]         rounds_used;
  modport source (output valid, eccentric_anomaly, converged, rounds_used, input ready);
  modport sink   (input valid, eccentric_anomaly, converged, rounds_used, output ready);
endinterface

@@ hdl/kens_cfg_if.sv @@
interface kens_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/kens_divider.sv @@
// Restoring divider, one quotient bit a cycle, saturating at the step cap.
module kens_divider import kens_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [35:0] num_i,   // magnitude
  input  logic [35:0] den_i,   // magnitude, non-zero
  output logic        done_o,
  output logic [34:0] quo_o
);

  // 36 numerator bits, then 30 fraction bits
  localparam int Bits = 66;

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [35:0] rem_q, rem_d;
  logic [35:0] num_q, num_d;
  logic [35:0] den_q, den_d;
  logic [35:0] q_q, q_d;
  logic        sat_q, sat_d;
  logic        done_q, done_d;
  logic [36:0] trial;
  logic [35:0] qn;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    q_d    = q_q;
    sat_d  = sat_q;
    done_d = 1'b0;
    trial  = '0;
    qn     = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'(Bits);
      rem_d  = '0;
      num_d  = num_i;
      den_d  = den_i;
      q_d    = '0;
      sat_d  = 1'b0;
    end else if (busy_q) begin
      // dividend bits beyond the numerator shift in as zeros
      trial = {rem_q, num_q[35]} - {1'b0, den_q};
      if (!trial[36]) begin
        rem_d = trial[35:0];
        qn    = {q_q[34:0], 1'b1};
      end else begin
        rem_d = {rem_q[34:0], num_q[35]};
        qn    = {q_q[34:0], 1'b0};
      end
      num_d = {num_q[34:0], 1'b0};
      if (sat_q || q_q[35] || (q_q[34:0] > {1'b0, StepCap[34:1]})
          || ({1'b0, qn[34:0]} > {1'b0, StepCap}) || qn[35]) begin
        sat_d = 1'b1;
        q_d   = {1'b0, StepCap};
      end else begin
        q_d = qn;
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    q_q   <= q_d;
    sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign quo_o  = sat_q ? StepCap : q_q[34:0];

endmodule

@@ hdl/kepler_equation_newton_solver.sv @@
// Kepler equation solver: Newton-Raphson on u - e*sin(u) = M, one word at a
// time. Each round reduces the angle, runs a 30-step CORDIC (one
// micro-rotation a cycle), two products and a restoring division.
// in.ready is low from acceptance until the result word is taken. The result
// gives the last estimate, a converged flag (0 when the round limit ends the
// solve with the last step still above the tolerance, the caller then
// resubmits with a new guess) and the rounds used.
module kepler_equation_newton_solver import kens_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  kens_cfg_if.sink   cfg,
  kens_in_if.sink    in,
  kens_out_if.source out
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRed   = 4'd1;
  localparam logic [3:0] StFold  = 4'd2;
  localparam logic [3:0] StCord  = 4'd3;
  localparam logic [3:0] StMulS  = 4'd4;
  localparam logic [3:0] StMulC  = 4'd5;
  localparam logic [3:0] StNum   = 4'd6;
  localparam logic [3:0] StDiv   = 4'd7;
  localparam logic [3:0] StUpd   = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  logic [3:0]  st_q, st_d;
  logic [15:0] tol_q;
  logic [7:0]  maxr_q;

  logic signed [35:0] m_q, e_q, u_q, old_q;
  logic signed [35:0] x_q, y_q, z_q;
  logic               flip_q;
  logic [StepW-1:0]   i_q;
  logic signed [35:0] es_q, den_q, num_q;
  logic [7:0]         rnd_q;
  logic               conv_q;

  logic signed [35:0] r_red, dx, dy, at, den_c, num_c, q_s, un;
  logic signed [31:0] mul_b;
  logic signed [62:0] prod;
  logic signed [36:0] diff;
  logic               div_start, div_done;
  logic [34:0]        div_q;
  logic [35:0]        num_mag;
  logic [7:0]         lim;
  logic               in_range;

  assign cfg.ready = 1'b1;
  assign in.ready  = (st_q == StIdle);
  assign out.valid = (st_q == StOut);
  assign out.eccentric_anomaly = u_q[31:0];
  assign out.converged = conv_q;
  assign out.rounds_used = rnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= 16'd1;
      maxr_q <= 8'd100;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CfgTolerance: tol_q  <= cfg.data;
        CfgMaxRounds: maxr_q <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // u in Q4.27 to Q.30; reduction into [-pi, pi] is done in StFold, a period a cycle
  always_comb begin
    r_red = u_q <<< (30 - AngleFracBits);
    in_range = (z_q <= PiQ30) && (z_q >= -PiQ30);
  end

  always_comb begin
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    at = atan_q30(i_q);
  end

  // |x|, |y| stay within one in Q.30, e below one
  assign mul_b = (st_q == StMulS) ? y_q[31:0] : x_q[31:0];
  assign prod  = $signed({1'b0, e_q[29:0]}) * mul_b;

  always_comb begin
    den_c = 36'((prod >>> 30) - 63'(OneQ30));
    if (flip_q) den_c = 36'(((-prod) >>> 30) - 63'(OneQ30));
    if (den_c > -36'sd1) den_c = -36'sd1;
    num_c = m_q + (es_q >>> (30 - AngleFracBits)) - u_q;
    num_mag = num_q[35] ? 36'(-num_q) : num_q;
  end

  assign div_start = (st_q == StNum);
  kens_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_mag),
    .den_i  (36'(-den_q)),
    .done_o (div_done),
    .quo_o  (div_q)
  );

  always_comb begin
    q_s = (num_q > 36'sd0) ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    un  = u_q - q_s;
    if (un > AngMax) un = AngMax;
    if (un < AngMin) un = AngMin;
    diff = {un[35], un} - {old_q[35], old_q};
    if (diff < 0) diff = -diff;
    lim = (maxr_q == 8'd0) ? 8'd1 : maxr_q;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (in.valid) st_d = StRed;
      StRed:  st_d = StFold;
      StFold: if (in_range) st_d = StCord;
      StCord: if (i_q == StepW'(CordicSteps - 1)) st_d = StMulS;
      StMulS: st_d = StMulC;
      StMulC: st_d = StNum;
      StNum:  st_d = StDiv;
      StDiv:  if (div_done) st_d = StUpd;
      StUpd: begin
        if ((diff > {21'd0, tol_q}) && ((rnd_q + 8'd1) < lim)) st_d = StRed;
        else st_d = StOut;
      end
      StOut:  if (out.ready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        m_q   <= {6'd0, in.mean_anomaly};
        e_q   <= {6'd0, in.eccentricity};
        u_q   <= {6'd0, in.initial_guess};
        rnd_q <= 8'd0;
      end
      StRed: begin
        old_q <= u_q;
        z_q   <= r_red;
      end
      StFold: begin
        if (z_q > PiQ30) begin
          z_q <= z_q - TwoPiQ30;
        end else if (z_q < -PiQ30) begin
          z_q <= z_q + TwoPiQ30;
        end else begin
          x_q <= GainQ30;
          y_q <= '0;
          i_q <= '0;
          if (z_q > HalfPiQ30) begin
            z_q <= PiQ30 - z_q;  flip_q <= 1'b1;
          end else if (z_q < -HalfPiQ30) begin
            z_q <= -PiQ30 - z_q; flip_q <= 1'b1;
          end else flip_q <= 1'b0;
        end
      end
      StCord: begin
        if (!z_q[35]) begin
          x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
        end
        i_q <= i_q + StepW'(1);
      end
      StMulS: es_q <= 36'(prod >>> 30);
      StMulC: begin
        den_q <= den_c;
        num_q <= num_c;
      end
      StUpd: begin
        u_q    <= un;
        rnd_q  <= rnd_q + 8'd1;
        conv_q <= (diff <= {21'd0, tol_q});
      end
      default: ;
    endcase
  end

endmodule
